FILE: rtl/lzbd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LZ back-reference byte decompressor.
// No dependencies; imported by every module of the block.
package lzbd_pkg;

    localparam int LZBD_WINDOW_BYTES = 131072;
    localparam int LZBD_Q_DEPTH      = 2;

    localparam int POS_W  = 24;
    localparam int LIT_W  = 7;
    localparam int COP_W  = 11;
    localparam int DIST_W = 18;

    localparam logic [7:0] MAGIC_PLAIN = 8'h10;
    localparam logic [7:0] MAGIC_ALT   = 8'h50;
    localparam logic [7:0] MAGIC_SIG   = 8'hFB;

    typedef enum logic [0:0] {
        OP_BYTE  = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BUSY    = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_TRUNC   = 3'd3,
        ST_BACKREF = 3'd4,
        ST_OVERRUN = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CONTROL,
        PH_EXTRA,
        PH_LITERALS,
        PH_COPY,
        PH_DONE,
        PH_FAILED
    } t_phase;

    typedef enum logic [2:0] {
        CC_SHORT,
        CC_MID,
        CC_LONG,
        CC_LITRUN,
        CC_LITSHORT
    } t_cls;

    typedef struct packed {
        t_op              op;
        logic [7:0]       data;
        logic             last;
        t_cls             cls;
        logic [LIT_W-1:0] lit;
    } t_item;

    typedef struct packed {
        logic [7:0] lit_byte;
        logic       byte_valid;
        logic       eoo;
        t_status    status;
        logic       from_mem;
        logic       wr;
    } t_res;

endpackage

FILE: rtl/lzbd_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transactions, classifies control bytes, queues items.
// Depends on lzbd_pkg.
module lzbd_front #(
    parameter int Q_DEPTH = lzbd_pkg::LZBD_Q_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_op,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    output logic           o_head_valid,
    output lzbd_pkg::t_item o_head,
    input  logic           i_pop
);
    import lzbd_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_item          r_q [Q_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  n_wp;
    logic [PW-1:0]  n_rp;
    logic [CW-1:0]  n_cnt;
    t_item          w_item;
    logic           w_push;

    always_comb begin
        w_item.op   = t_op'(i_op);
        w_item.data = i_data_byte;
        w_item.last = i_last_byte;
        w_item.lit  = {5'd0, i_data_byte[1:0]};
        if (i_data_byte >= 8'd252) begin
            w_item.cls = CC_LITSHORT;
        end else if (i_data_byte >= 8'd224) begin
            w_item.cls = CC_LITRUN;
            w_item.lit = {i_data_byte[4:0], 2'b00} + 7'd4;
        end else if (i_data_byte >= 8'd192) begin
            w_item.cls = CC_LONG;
        end else if (i_data_byte >= 8'd128) begin
            w_item.cls = CC_MID;
        end else begin
            w_item.cls = CC_SHORT;
        end
    end

    assign o_in_ready   = (r_cnt != CW'(Q_DEPTH));
    assign w_push       = i_in_valid && o_in_ready;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({w_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

endmodule

FILE: rtl/lzbd_back.sv
`timescale 1ns / 1ps
// Back end: header check, token decode and run sequencing, one item per cycle
// while i_s2_free is high. Depends on lzbd_pkg; drives history stage lzbd_hist.
module lzbd_back #(
    parameter int WINDOW_BYTES = lzbd_pkg::LZBD_WINDOW_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_head_valid,
    input  lzbd_pkg::t_item                  i_head,
    input  logic                             i_s2_free,
    output logic                             o_pop,
    output lzbd_pkg::t_res                   o_res,
    output logic [$clog2(WINDOW_BYTES)-1:0]  o_wr_addr,
    output logic [$clog2(WINDOW_BYTES)-1:0]  o_rd_addr
);
    import lzbd_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);

    typedef enum logic [1:0] {
        TL_NONE,
        TL_START,
        TL_BEGIN,
        TL_FINISH
    } t_tail;

    t_phase              r_phase, n_phase;
    t_status             r_err, n_err;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [POS_W-1:0]    r_size, n_size;
    logic [2:0]          r_hc, n_hc;
    logic [7:0]          r_tok [3];
    logic [7:0]          n_tok [3];
    logic [7:0]          tok_e [3];
    logic [LIT_W-1:0]    r_lit, n_lit;
    logic [COP_W-1:0]    r_cop, n_cop;
    logic [DIST_W-1:0]   r_dist, n_dist;
    logic                r_ended, n_ended;
    logic [7:0]          r_ctrl, n_ctrl;
    logic [1:0]          r_need, n_need;

    logic                w_fire;
    t_res                w_res;
    t_tail               w_tail;
    logic                w_put;
    logic                w_fail;
    t_status             w_fcode;
    logic [LIT_W-1:0]    w_lit_e;
    logic [COP_W-1:0]    w_cop_e;
    logic [DIST_W-1:0]   w_dist_e;
    logic                w_last_e;
    logic                w_ovr;
    logic                w_past;
    logic                w_far;
    logic                w_done;
    logic                w_do_begin;
    logic                w_do_finish;
    logic [7:0]          w_c;

    assign w_fire    = i_head_valid && i_s2_free;
    assign o_pop     = w_fire;
    assign o_res     = w_res;
    assign o_wr_addr = r_pos[AW-1:0];
    assign o_rd_addr = r_pos[AW-1:0] - r_dist[AW-1:0];
    assign w_c       = r_ctrl;

    always_comb begin
        n_phase  = r_phase;
        n_err    = r_err;
        n_pos    = r_pos;
        n_size   = r_size;
        n_hc     = r_hc;
        n_tok    = r_tok;
        tok_e    = r_tok;
        n_lit    = r_lit;
        n_cop    = r_cop;
        n_dist   = r_dist;
        n_ended  = r_ended;
        n_ctrl   = r_ctrl;
        n_need   = r_need;
        w_res    = '0;
        w_res.status = ST_OK;
        w_tail   = TL_NONE;
        w_put    = 1'b0;
        w_fail   = 1'b0;
        w_fcode  = ST_OK;
        w_lit_e  = '0;
        w_cop_e  = '0;
        w_dist_e = '0;
        w_last_e = i_head.last;

        if (w_fire) begin
            if (r_phase == PH_FAILED) begin
                w_res.status = r_err;
            end else if (r_phase == PH_DONE) begin
                w_res.status = ST_OK;
            end else if (i_head.op == OP_DRAIN) begin
                if (r_phase == PH_COPY) begin
                    w_put          = 1'b1;
                    w_res.from_mem = 1'b1;
                    n_cop          = r_cop - 1'b1;
                    if (r_cop == COP_W'(1)) begin
                        w_tail   = TL_FINISH;
                        w_last_e = r_ended;
                    end
                end
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_hc < 3'd2) begin
                            n_tok[r_hc[1:0]] = i_head.data;
                        end else begin
                            n_size = {r_size[15:0], i_head.data};
                        end
                        if (r_hc < 3'd4) begin
                            n_hc = r_hc + 1'b1;
                            if (i_head.last) begin
                                w_fail  = 1'b1;
                                w_fcode = ST_TRUNC;
                            end
                        end else if ((r_tok[0] != MAGIC_PLAIN && r_tok[0] != MAGIC_ALT) ||
                                     r_tok[1] != MAGIC_SIG) begin
                            w_fail  = 1'b1;
                            w_fcode = ST_MAGIC;
                        end else begin
                            n_tok[0] = '0;
                            n_tok[1] = '0;
                            w_tail   = TL_FINISH;
                        end
                    end
                    PH_CONTROL: begin
                        case (i_head.cls)
                            CC_LITSHORT, CC_LITRUN: begin
                                w_tail  = TL_START;
                                w_lit_e = i_head.lit;
                            end
                            default: begin
                                n_ctrl = i_head.data;
                                n_need = (i_head.cls == CC_LONG) ? 2'd3 :
                                         (i_head.cls == CC_MID)  ? 2'd2 : 2'd1;
                                n_hc   = '0;
                                if (i_head.last) begin
                                    w_fail  = 1'b1;
                                    w_fcode = ST_TRUNC;
                                end else begin
                                    n_phase = PH_EXTRA;
                                end
                            end
                        endcase
                    end
                    PH_EXTRA: begin
                        tok_e[r_hc[1:0]] = i_head.data;
                        n_tok            = tok_e;
                        n_hc             = r_hc + 1'b1;
                        if ((r_hc[1:0] + 2'd1) >= r_need) begin
                            w_tail = TL_START;
                            if (w_c[7:6] == 2'b11) begin
                                w_lit_e  = {5'd0, w_c[1:0]};
                                w_cop_e  = COP_W'({w_c[3:2], 8'h00}) + COP_W'(tok_e[2])
                                           + COP_W'(5);
                                w_dist_e = DIST_W'({w_c[4], 16'h0000})
                                           + DIST_W'({tok_e[0], tok_e[1]}) + DIST_W'(1);
                            end else if (w_c[7]) begin
                                w_lit_e  = {5'd0, tok_e[0][7:6]};
                                w_cop_e  = COP_W'(w_c[5:0]) + COP_W'(4);
                                w_dist_e = DIST_W'({tok_e[0][5:0], tok_e[1]}) + DIST_W'(1);
                            end else begin
                                w_lit_e  = {5'd0, w_c[1:0]};
                                w_cop_e  = COP_W'(w_c[4:2]) + COP_W'(3);
                                w_dist_e = DIST_W'({w_c[6:5], tok_e[0]}) + DIST_W'(1);
                            end
                        end else if (i_head.last) begin
                            w_fail  = 1'b1;
                            w_fcode = ST_TRUNC;
                        end
                    end
                    PH_LITERALS: begin
                        w_put          = 1'b1;
                        w_res.lit_byte = i_head.data;
                        n_lit          = r_lit - 1'b1;
                        if (r_lit != LIT_W'(1)) begin
                            if (i_head.last) begin
                                w_fail  = 1'b1;
                                w_fcode = ST_TRUNC;
                            end
                        end else if (r_cop != '0) begin
                            w_tail   = TL_BEGIN;
                            w_cop_e  = r_cop;
                            w_dist_e = r_dist;
                        end else begin
                            w_tail = TL_FINISH;
                        end
                    end
                    PH_COPY: begin
                        w_res.status = ST_BUSY;
                    end
                    default: begin
                        w_res.status = ST_OK;
                    end
                endcase
            end
        end

        if (w_put) begin
            n_pos            = r_pos + 1'b1;
            w_res.byte_valid = 1'b1;
            w_res.wr         = 1'b1;
        end

        w_ovr  = ({1'b0, n_pos} + (POS_W + 1)'(w_lit_e)) > {1'b0, n_size};
        w_past = ({1'b0, n_pos} + (POS_W + 1)'(w_cop_e)) > {1'b0, n_size};
        w_far  = POS_W'(w_dist_e) > n_pos;
        w_done = n_pos >= n_size;

        w_do_begin  = (w_tail == TL_BEGIN) ||
                      (w_tail == TL_START && w_lit_e == '0 && w_cop_e != '0);
        w_do_finish = (w_tail == TL_FINISH) ||
                      (w_tail == TL_START && w_lit_e == '0 && w_cop_e == '0);

        if (w_tail == TL_START) begin
            n_lit  = w_lit_e;
            n_cop  = w_cop_e;
            n_dist = w_dist_e;
            if (w_lit_e != '0) begin
                if (w_ovr) begin
                    w_fail  = 1'b1;
                    w_fcode = ST_OVERRUN;
                end else if (w_last_e) begin
                    w_fail  = 1'b1;
                    w_fcode = ST_TRUNC;
                end else begin
                    n_phase = PH_LITERALS;
                end
            end
        end

        if (w_do_begin) begin
            if (w_far || w_past) begin
                w_fail  = 1'b1;
                w_fcode = ST_BACKREF;
            end else begin
                n_ended = w_last_e;
                n_phase = PH_COPY;
            end
        end

        if (w_do_finish) begin
            if (w_done) begin
                n_phase   = PH_DONE;
                w_res.eoo = 1'b1;
            end else if (w_last_e) begin
                w_fail  = 1'b1;
                w_fcode = ST_TRUNC;
            end else begin
                n_phase = PH_CONTROL;
            end
        end

        if (w_fail) begin
            n_phase      = PH_FAILED;
            n_err        = w_fcode;
            w_res.eoo    = 1'b0;
            w_res.status = w_fcode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_err   <= ST_OK;
            r_pos   <= '0;
            r_size  <= '0;
            r_hc    <= '0;
            r_tok   <= '{default: '0};
            r_lit   <= '0;
            r_cop   <= '0;
            r_dist  <= '0;
            r_ended <= 1'b0;
            r_ctrl  <= '0;
            r_need  <= '0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_err   <= n_err;
            r_pos   <= n_pos;
            r_size  <= n_size;
            r_hc    <= n_hc;
            r_tok   <= n_tok;
            r_lit   <= n_lit;
            r_cop   <= n_cop;
            r_dist  <= n_dist;
            r_ended <= n_ended;
            r_ctrl  <= n_ctrl;
            r_need  <= n_need;
        end
    end

endmodule

FILE: rtl/lzbd_hist.sv
`timescale 1ns / 1ps
// History window memory with write forwarding, and the output result register.
// Depends on lzbd_pkg; fed by lzbd_back.
module lzbd_hist #(
    parameter int WINDOW_BYTES = lzbd_pkg::LZBD_WINDOW_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  lzbd_pkg::t_res                   i_res,
    input  logic [$clog2(WINDOW_BYTES)-1:0]  i_wr_addr,
    input  logic [$clog2(WINDOW_BYTES)-1:0]  i_rd_addr,
    output logic                             o_s2_free,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_out_byte,
    output logic                             o_byte_valid,
    output logic                             o_end_of_output,
    output logic [2:0]                       o_status
);
    import lzbd_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);

    logic [7:0]     r_mem [WINDOW_BYTES];
    logic [7:0]     r_rdata;
    logic           r_s2_valid;
    t_res           r_s2;
    logic [AW-1:0]  r_s2_wa;
    logic [AW-1:0]  r_s2_ra;
    logic           r_fwd_vld;
    logic [AW-1:0]  r_fwd_addr;
    logic [7:0]     r_fwd_byte;
    logic           w_leave;
    logic           w_wr;
    logic [7:0]     w_byte;

    assign w_leave   = r_s2_valid && i_out_ready;
    assign o_s2_free = !r_s2_valid || i_out_ready;
    assign w_wr      = w_leave && r_s2.wr;

    always_comb begin
        if (r_s2.from_mem) begin
            w_byte = (r_fwd_vld && r_fwd_addr == r_s2_ra) ? r_fwd_byte : r_rdata;
        end else begin
            w_byte = r_s2.lit_byte;
        end
    end

    assign o_out_valid     = r_s2_valid;
    assign o_out_byte      = w_byte;
    assign o_byte_valid    = r_s2.byte_valid;
    assign o_end_of_output = r_s2.eoo;
    assign o_status        = r_s2.status;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_s2_wa] <= w_byte;
        end
        if (i_fire) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_fwd_vld  <= 1'b0;
        end else begin
            if (i_fire) begin
                r_s2_valid <= 1'b1;
            end else if (w_leave) begin
                r_s2_valid <= 1'b0;
            end
            if (w_wr) begin
                r_fwd_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_s2    <= i_res;
            r_s2_wa <= i_wr_addr;
            r_s2_ra <= i_rd_addr;
        end
        if (w_wr) begin
            r_fwd_addr <= r_s2_wa;
            r_fwd_byte <= w_byte;
        end
    end

endmodule

FILE: rtl/lz_backref_byte_decompressor_unit.sv
`timescale 1ns / 1ps
// Each result passes through the input queue register and then the history stage result
// register before it is presented, and waits there while i_out_ready is low.
// Throughput: one input transaction per cycle while i_out_ready is high, bytes and drain
// ticks alike; the decode sequencer and one history read and write per cycle set it.
// Reset (i_rst_n low, synchronous) clears the queue, decoder state and output valid;
// the 128 KiB history is not cleared and needs no clearing pass.
module lz_backref_byte_decompressor_unit #(
    parameter int WINDOW_BYTES = lzbd_pkg::LZBD_WINDOW_BYTES,
    parameter int Q_DEPTH      = lzbd_pkg::LZBD_Q_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_op,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_end_of_output,
    output logic [2:0] o_status
);
    import lzbd_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);

    logic           w_head_valid;
    t_item          w_head;
    logic           w_pop;
    logic           w_s2_free;
    t_res           w_res;
    logic [AW-1:0]  w_wr_addr;
    logic [AW-1:0]  w_rd_addr;

    lzbd_front #(
        .Q_DEPTH (Q_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    lzbd_back #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .i_s2_free    (w_s2_free),
        .o_pop        (w_pop),
        .o_res        (w_res),
        .o_wr_addr    (w_wr_addr),
        .o_rd_addr    (w_rd_addr)
    );

    lzbd_hist #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_hist (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_pop),
        .i_res           (w_res),
        .i_wr_addr       (w_wr_addr),
        .i_rd_addr       (w_rd_addr),
        .o_s2_free       (w_s2_free),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_output (o_end_of_output),
        .o_status        (o_status)
    );

    a_no_byte_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_out_byte == 8'd0)
        else $error("result without a byte carries a nonzero byte");

    a_end_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_output |-> o_status == ST_OK)
        else $error("end of output flagged on a failing result");

    a_copy_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && w_res.from_mem |-> w_res.byte_valid && w_res.wr)
        else $error("copy byte issued without history write");

    a_pop_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid && w_s2_free)
        else $error("queue popped without item or output room");

endmodule
